[design/assert_macros.svh]
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// consequence holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/mbt_pkg.sv]
// types, codes and the sigmoid table of the perceptron trainer
package mbt_pkg;

    localparam logic [2:0] MODE_LOAD_WEIGHT = 3'd0;
    localparam logic [2:0] MODE_INPUT       = 3'd1;
    localparam logic [2:0] MODE_TARGET      = 3'd2;
    localparam logic [2:0] MODE_CLASSIFY    = 3'd3;
    localparam logic [2:0] MODE_TRAIN       = 3'd4;

    localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706256;

    typedef struct packed {
        logic [2:0]         mode;
        logic               weight_layer;
        logic [3:0]         source_index;
        logic [2:0]         dest_index;
        logic [2:0]         element_index;
        logic signed [23:0] data_value;
    } t_in_req;

    typedef struct packed {
        logic [2:0]         output_index;
        logic signed [23:0] output_value;
        logic [22:0]        error_sum;
        logic               last;
    } t_out_req;

    typedef logic [255:0][16:0] t_rom;

    // restoring division, only used while the table is built
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid at bin centers, built once at elaboration
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] v;
        rom = '0;
        p = EXP_STEP_Q30;
        for (int k = 128; k < 256; k++) begin
            den = (64'd1 << 30) + p;
            v = udiv64((64'd1 << 46) + (den >> 1), den);
            rom[k] = v[16:0];
            rom[255 - k] = 17'd65536 - v[16:0];
            p = (p * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
            p = (p * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
        end
        return rom;
    endfunction

endpackage

[design/mbt_wmem.sv]
// weight and change memory, write and read share one address, zero until written
module mbt_wmem
    import mbt_pkg::*;
#(
    parameter int DEPTH = 108,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [47:0]   i_wdata,
    output logic [47:0]   o_rdata
);

    logic [47:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [47:0]      r_q;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // written flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_addr] <= 1'b1;
        end
    end

    // registered read, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_vld[i_addr] ? r_mem[i_addr] : 48'd0;
        end
    end

    assign o_rdata = r_q;

endmodule

[design/mbt_sig.sv]
// sigmoid lookup with clamp to [-8, 8)
module mbt_sig
    import mbt_pkg::*;
(
    input  logic signed [23:0] i_x,
    output logic signed [23:0] o_y
);

    localparam t_rom SIG_ROM = build_rom();

    logic [23:0] shifted;
    logic [7:0]  idx;

    // bin index floor((x+8)*16)
    always_comb begin
        shifted = i_x + 24'sd524288;
        if (i_x < -24'sd524288) begin
            idx = 8'd0;
        end else if (i_x > 24'sd524287) begin
            idx = 8'd255;
        end else begin
            idx = shifted[19:12];
        end
    end

    assign o_y = {7'd0, SIG_ROM[idx]};

endmodule

[design/mlp_backprop_trainer_core.sv]
// two-layer sigmoid perceptron trainer: sequencer, shared multiplier, state stores
//
//  channel   direction  handshake                   payload
//  in        request    i_in_valid / o_in_stall     i_in_req  (t_in_req)
//  out       result     o_out_valid / i_out_stall   o_out_req (t_out_req)
//  apb       config     psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// load items finish in the idle step. classify and train step through the weights
// one at a time: one shared multiplier and one memory read port set the pace.
// reset clears all stores; weights read as zero until loaded.
// a stalled result holds the sequencer in its emit step; new requests wait until idle.
module mlp_backprop_trainer_core
    import mbt_pkg::*;
#(
    parameter int NUM_INPUTS  = 8,
    parameter int NUM_HIDDEN  = 8,
    parameter int NUM_OUTPUTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_req    o_out_req,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    localparam int HW    = (NUM_INPUTS + 1) * NUM_HIDDEN;
    localparam int OW    = (NUM_HIDDEN + 1) * NUM_OUTPUTS;
    localparam int DEPTH = HW + OW;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_FRD  = 5'd1;
    localparam logic [4:0] ST_FAC  = 5'd2;
    localparam logic [4:0] ST_FACT = 5'd3;
    localparam logic [4:0] ST_DE2  = 5'd4;
    localparam logic [4:0] ST_DM1  = 5'd5;
    localparam logic [4:0] ST_DM2  = 5'd6;
    localparam logic [4:0] ST_BRD  = 5'd7;
    localparam logic [4:0] ST_BAC  = 5'd8;
    localparam logic [4:0] ST_BM1  = 5'd9;
    localparam logic [4:0] ST_BM2  = 5'd10;
    localparam logic [4:0] ST_URD  = 5'd11;
    localparam logic [4:0] ST_UM1  = 5'd12;
    localparam logic [4:0] ST_UM2  = 5'd13;
    localparam logic [4:0] ST_UWR  = 5'd14;
    localparam logic [4:0] ST_EM   = 5'd15;

    function automatic logic signed [23:0] sat24(input logic signed [51:0] v);
        if (v > 52'sd8388607) begin
            return 24'sd8388607;
        end
        if (v < -52'sd8388608) begin
            return -24'sd8388608;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [51:0] rnd16(input logic signed [51:0] v);
        return (v + 52'sd32768) >>> 16;
    endfunction

    logic [4:0]         r_state;
    logic               r_lay;
    logic               r_train;
    logic [2:0]         r_node;
    logic [3:0]         r_row;
    logic signed [51:0] r_acc;
    logic [22:0]        r_es;
    logic signed [23:0] r_e;
    logic signed [23:0] r_t;
    logic signed [33:0] r_p;
    logic [15:0]        r_lr;
    logic [15:0]        r_mom;
    logic signed [23:0] r_inp  [0:7];
    logic signed [23:0] r_tgt  [0:7];
    logic signed [23:0] r_hact [0:7];
    logic signed [23:0] r_oact [0:7];
    logic signed [23:0] r_hd   [0:7];
    logic signed [23:0] r_od   [0:7];
    logic               r_out_valid;
    t_out_req           r_out;

    logic               in_acc;
    logic               load_ok;
    logic [3:0]         fanin;
    logic [2:0]         last_node;
    logic signed [24:0] act;
    logic signed [23:0] delta;
    logic signed [24:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [49:0] prod;
    logic signed [51:0] prod52;
    logic signed [51:0] prod_r;
    logic signed [23:0] sum_x;
    logic signed [23:0] sig_y;
    logic signed [24:0] diff;
    logic signed [23:0] err;
    logic signed [51:0] sq;
    logic signed [51:0] es_sum;
    logic signed [51:0] upd_sum;
    logic signed [51:0] w_sum;
    logic               a_lay;
    logic [3:0]         a_row;
    logic [2:0]         a_col;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic               mem_re;
    logic [47:0]        mem_wdata;
    logic [47:0]        mem_q;
    logic signed [23:0] q_w;
    logic signed [23:0] q_c;
    logic               out_free;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign q_w        = mem_q[47:24];
    assign q_c        = mem_q[23:0];
    assign out_free   = !r_out_valid || !i_out_stall;

    // config port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, r_mom} : {16'd0, r_lr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= 16'd19661;
            r_mom <= 16'd58982;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_mom <= pwdata[15:0];
            end else begin
                r_lr <= pwdata[15:0];
            end
        end
    end

    // layer geometry and operand selection
    always_comb begin
        fanin     = r_lay ? 4'(NUM_HIDDEN) : 4'(NUM_INPUTS);
        last_node = r_lay ? 3'(NUM_OUTPUTS - 1) : 3'(NUM_HIDDEN - 1);
        if (r_row == fanin) begin
            act = 25'sd65536;
        end else if (r_lay) begin
            act = {r_hact[r_row[2:0]][23], r_hact[r_row[2:0]]};
        end else begin
            act = {r_inp[r_row[2:0]][23], r_inp[r_row[2:0]]};
        end
        delta = r_lay ? r_od[r_node] : r_hd[r_node];
        if (i_in_req.weight_layer) begin
            load_ok = (i_in_req.source_index <= 4'(NUM_HIDDEN)) &&
                      ({1'b0, i_in_req.dest_index} < 4'(NUM_OUTPUTS));
        end else begin
            load_ok = (i_in_req.source_index <= 4'(NUM_INPUTS)) &&
                      ({1'b0, i_in_req.dest_index} < 4'(NUM_HIDDEN));
        end
    end

    // memory address and port control
    always_comb begin
        if (r_state == ST_IDLE) begin
            a_lay = i_in_req.weight_layer;
            a_row = i_in_req.source_index;
            a_col = i_in_req.dest_index;
        end else if (r_state == ST_BRD) begin
            a_lay = 1'b1;
            a_row = {1'b0, r_node};
            a_col = r_row[2:0];
        end else begin
            a_lay = r_lay;
            a_row = r_row;
            a_col = r_node;
        end
        if (a_lay) begin
            mem_addr = AW'(HW + int'(a_row) * NUM_OUTPUTS + int'(a_col));
        end else begin
            mem_addr = AW'(int'(a_row) * NUM_HIDDEN + int'(a_col));
        end
        mem_re = (r_state == ST_FRD) || (r_state == ST_BRD) || (r_state == ST_URD);
        w_sum  = {{28{q_w[23]}}, q_w} + {{28{r_t[23]}}, r_t};
        if (r_state == ST_UWR) begin
            mem_we    = 1'b1;
            mem_wdata = {sat24(w_sum), r_t};
        end else begin
            mem_we    = in_acc && (i_in_req.mode == MODE_LOAD_WEIGHT) && load_ok;
            mem_wdata = {i_in_req.data_value, 24'd0};
        end
    end

    mbt_wmem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_q)
    );

    // activation of the finished dot product
    assign sum_x = sat24(rnd16(r_acc));

    mbt_sig u_sig (
        .i_x (sum_x),
        .o_y (sig_y)
    );

    // shared multiplier operands
    always_comb begin
        diff = {r_tgt[r_node][23], r_tgt[r_node]} - {r_oact[r_node][23], r_oact[r_node]};
        err  = sat24({{27{diff[24]}}, diff});
        case (r_state)
            ST_FAC: begin
                mul_a = act;
                mul_b = {q_w[23], q_w};
            end
            ST_DE2: begin
                mul_a = {err[23], err};
                mul_b = {err[23], err};
            end
            ST_DM1: begin
                mul_a = {r_e[23], r_e};
                mul_b = {r_oact[r_node][23], r_oact[r_node]};
            end
            ST_DM2: begin
                mul_a = {r_t[23], r_t};
                mul_b = 25'sd65536 - {r_oact[r_node][23], r_oact[r_node]};
            end
            ST_BAC: begin
                mul_a = {q_w[23], q_w};
                mul_b = {r_od[r_row[2:0]][23], r_od[r_row[2:0]]};
            end
            ST_BM1: begin
                mul_a = {sum_x[23], sum_x};
                mul_b = {r_hact[r_node][23], r_hact[r_node]};
            end
            ST_BM2: begin
                mul_a = {r_t[23], r_t};
                mul_b = 25'sd65536 - {r_hact[r_node][23], r_hact[r_node]};
            end
            ST_URD: begin
                mul_a = {9'd0, r_lr};
                mul_b = {delta[23], delta};
            end
            ST_UM1: begin
                mul_a = {r_t[23], r_t};
                mul_b = act;
            end
            ST_UM2: begin
                mul_a = {9'd0, r_mom};
                mul_b = {q_c[23], q_c};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod    = mul_a * mul_b;
        prod52  = {{2{prod[49]}}, prod};
        prod_r  = rnd16(prod52);
        sq      = (prod52 + 52'sd65536) >>> 17;
        es_sum  = {29'd0, r_es} + sq;
        upd_sum = {{18{r_p[33]}}, r_p} + prod_r;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lay       <= 1'b0;
            r_train     <= 1'b0;
            r_node      <= '0;
            r_row       <= '0;
            r_acc       <= '0;
            r_es        <= '0;
            r_e         <= '0;
            r_t         <= '0;
            r_p         <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            for (int i = 0; i < 8; i++) begin
                r_inp[i]  <= '0;
                r_tgt[i]  <= '0;
                r_hact[i] <= '0;
                r_oact[i] <= '0;
                r_hd[i]   <= '0;
                r_od[i]   <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && !(r_state == ST_EM && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_lay  <= 1'b0;
                        r_node <= '0;
                        r_row  <= '0;
                        r_acc  <= '0;
                        r_es   <= '0;
                        case (i_in_req.mode)
                            MODE_INPUT: begin
                                if ({1'b0, i_in_req.element_index} < 4'(NUM_INPUTS)) begin
                                    r_inp[i_in_req.element_index] <= i_in_req.data_value;
                                end
                            end
                            MODE_TARGET: begin
                                if ({1'b0, i_in_req.element_index} < 4'(NUM_OUTPUTS)) begin
                                    r_tgt[i_in_req.element_index] <= i_in_req.data_value;
                                end
                            end
                            MODE_CLASSIFY: begin
                                r_train <= 1'b0;
                                r_state <= ST_FRD;
                            end
                            MODE_TRAIN: begin
                                r_train <= 1'b1;
                                r_state <= ST_FRD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_FRD: begin
                    r_state <= ST_FAC;
                end
                // forward dot product, bias row last
                ST_FAC: begin
                    r_acc <= r_acc + prod52;
                    if (r_row == fanin) begin
                        r_state <= ST_FACT;
                    end else begin
                        r_row   <= r_row + 4'd1;
                        r_state <= ST_FRD;
                    end
                end
                ST_FACT: begin
                    if (r_lay) begin
                        r_oact[r_node] <= sig_y;
                    end else begin
                        r_hact[r_node] <= sig_y;
                    end
                    r_acc <= '0;
                    r_row <= '0;
                    if (r_node != last_node) begin
                        r_node  <= r_node + 3'd1;
                        r_state <= ST_FRD;
                    end else if (!r_lay) begin
                        r_lay   <= 1'b1;
                        r_node  <= '0;
                        r_state <= ST_FRD;
                    end else begin
                        r_node  <= '0;
                        r_state <= r_train ? ST_DE2 : ST_EM;
                    end
                end
                // output deltas and error sum
                ST_DE2: begin
                    r_e     <= err;
                    r_es    <= (es_sum > 52'sd8388607) ? 23'h7FFFFF : es_sum[22:0];
                    r_state <= ST_DM1;
                end
                ST_DM1: begin
                    r_t     <= sat24(prod_r);
                    r_state <= ST_DM2;
                end
                ST_DM2: begin
                    r_od[r_node] <= sat24(prod_r);
                    if (r_node != 3'(NUM_OUTPUTS - 1)) begin
                        r_node  <= r_node + 3'd1;
                        r_state <= ST_DE2;
                    end else begin
                        r_node  <= '0;
                        r_row   <= '0;
                        r_acc   <= '0;
                        r_state <= ST_BRD;
                    end
                end
                // hidden deltas from the old output weights
                ST_BRD: begin
                    r_state <= ST_BAC;
                end
                ST_BAC: begin
                    r_acc <= r_acc + prod52;
                    if (r_row == 4'(NUM_OUTPUTS - 1)) begin
                        r_state <= ST_BM1;
                    end else begin
                        r_row   <= r_row + 4'd1;
                        r_state <= ST_BRD;
                    end
                end
                ST_BM1: begin
                    r_t     <= sat24(prod_r);
                    r_state <= ST_BM2;
                end
                ST_BM2: begin
                    r_hd[r_node] <= sat24(prod_r);
                    r_acc        <= '0;
                    r_row        <= '0;
                    if (r_node != 3'(NUM_HIDDEN - 1)) begin
                        r_node  <= r_node + 3'd1;
                        r_state <= ST_BRD;
                    end else begin
                        r_node  <= '0;
                        r_lay   <= 1'b0;
                        r_state <= ST_URD;
                    end
                end
                // momentum update, read-modify-write of one weight
                ST_URD: begin
                    r_t     <= sat24(prod_r);
                    r_state <= ST_UM1;
                end
                ST_UM1: begin
                    r_p     <= prod_r[33:0];
                    r_state <= ST_UM2;
                end
                ST_UM2: begin
                    r_t     <= sat24(upd_sum);
                    r_state <= ST_UWR;
                end
                ST_UWR: begin
                    if (r_row != fanin) begin
                        r_row   <= r_row + 4'd1;
                        r_state <= ST_URD;
                    end else begin
                        r_row <= '0;
                        if (r_node != last_node) begin
                            r_node  <= r_node + 3'd1;
                            r_state <= ST_URD;
                        end else if (!r_lay) begin
                            r_lay   <= 1'b1;
                            r_node  <= '0;
                            r_state <= ST_URD;
                        end else begin
                            r_node  <= '0;
                            r_state <= ST_EM;
                        end
                    end
                end
                // result emission
                ST_EM: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_train) begin
                            r_out.output_index <= '0;
                            r_out.output_value <= '0;
                            r_out.error_sum    <= r_es;
                            r_out.last         <= 1'b1;
                            r_state            <= ST_IDLE;
                        end else begin
                            r_out.output_index <= r_node;
                            r_out.output_value <= r_oact[r_node];
                            r_out.error_sum    <= '0;
                            r_out.last         <= (r_node == 3'(NUM_OUTPUTS - 1));
                            if (r_node == 3'(NUM_OUTPUTS - 1)) begin
                                r_node  <= '0;
                                r_state <= ST_IDLE;
                            end else begin
                                r_node <= r_node + 3'd1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // checks
    `ASSERT_IMPLIES(a_no_write_fwd, r_state == ST_FRD || r_state == ST_FAC || r_state == ST_FACT, !mem_we)
    `ASSERT_IMPLIES(a_out_from_emit, $rose(r_out_valid), $past(r_state) == ST_EM)
    `ASSERT_NEXT(a_run_starts, in_acc && (i_in_req.mode == MODE_CLASSIFY || i_in_req.mode == MODE_TRAIN), r_state == ST_FRD)

endmodule
